>>> hdl/epvu_pkg.sv
`default_nettype none

package epvu_pkg;

    // Configuration register indexes.
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SCALE_FACTOR   = 3'd0;
    localparam t_cfg_idx CFG_EDGE_MODE      = 3'd1;
    localparam t_cfg_idx CFG_EDGE_THRESHOLD = 3'd2;
    localparam t_cfg_idx CFG_IMAGE_WIDTH    = 3'd3;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT   = 3'd4;

    localparam int SAMPLE_W = 16;
    localparam int ROW_W    = 10;
    localparam int COL_W    = 11;

    localparam int JOB_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 4;

    // Division by the scale is a multiply by a rounded-up reciprocal.
    // With numerators below 2**20 and divisors up to 16 the quotient is exact.
    localparam int DIV_NUM_W = 20;
    localparam int DIV_SHIFT = 24;
    localparam int RECIP_W   = 25;

    // One column's work: lower and upper samples and what to emit for them.
    typedef struct packed {
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] up;
        logic [ROW_W-1:0]    row_base;
        logic [COL_W-1:0]    col;
        logic                do_interp;
        logic                do_last;
        logic                is_edge;
        logic                is_zero;
    } t_job;

    typedef struct packed {
        logic [ROW_W-1:0]    out_row;
        logic [COL_W-1:0]    out_col;
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } t_result;

    function automatic logic [RECIP_W-1:0] recip(input logic [4:0] div);
        logic [RECIP_W-1:0] r;
        case (div)
            5'd2:    r = 25'd8388608;
            5'd3:    r = 25'd5592406;
            5'd4:    r = 25'd4194304;
            5'd5:    r = 25'd3355444;
            5'd6:    r = 25'd2796203;
            5'd7:    r = 25'd2396746;
            5'd8:    r = 25'd2097152;
            5'd9:    r = 25'd1864136;
            5'd10:   r = 25'd1677722;
            5'd11:   r = 25'd1525202;
            5'd12:   r = 25'd1398102;
            5'd13:   r = 25'd1290556;
            5'd14:   r = 25'd1198373;
            5'd15:   r = 25'd1118482;
            5'd16:   r = 25'd1048576;
            default: r = 25'd16777216;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/epvu_ram.sv
`default_nettype none

module epvu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/epvu_queue.sv
`default_nettype none

module epvu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push & ~o_full;
    assign rd_en   = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (wr_en) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (rd_en) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        n_count = r_count + CW'(wr_en) - CW'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/epvu_front.sv
`default_nettype none

module epvu_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 128,
    parameter int MAX_SCALE  = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_push,
    input  wire logic [epvu_pkg::SAMPLE_W-1:0]     i_sample,
    output logic                                   o_full,
    input  wire logic [$clog2(MAX_SCALE+1)-1:0]    i_scale,
    input  wire logic                              i_edge_mode,
    input  wire logic [epvu_pkg::SAMPLE_W-1:0]     i_threshold,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    i_width,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]   i_height,
    output epvu_pkg::t_job                         o_job,
    output logic                                   o_job_push,
    input  wire logic                              i_job_full
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SW  = $clog2(MAX_SCALE + 1);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int BW  = RW + SW;
    localparam int DW  = epvu_pkg::SAMPLE_W;
    localparam int RWO = epvu_pkg::ROW_W;
    localparam int CWO = epvu_pkg::COL_W;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          col_end, row_end;
    logic          accept, need;

    logic          r_s1_valid;
    logic [DW-1:0] r_s1_cur;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic          r_s1_interp;
    logic          r_s1_last;

    logic [DW-1:0] ram_rdata;
    logic [DW-1:0] diff;
    logic [RW-1:0] row_m;
    logic [BW-1:0] base_full;

    assign need       = r_s1_interp | r_s1_last;
    assign o_full     = r_s1_valid & need & i_job_full;
    assign accept     = i_push & ~o_full;
    assign o_job_push = r_s1_valid & need & ~i_job_full;

    // The store is read and rewritten at the same column on the same clock edge; the
    // registered read returns the previous row's sample.
    epvu_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (i_sample),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    assign col_end = (WW'(r_col) + WW'(1)) >= i_width;
    assign row_end = (HW'(r_row) + HW'(1)) >= i_height;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (r_s1_valid && (!need || !i_job_full)) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cur    <= i_sample;
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
            r_s1_interp <= (r_row != '0);
            r_s1_last   <= row_end;
        end
    end

    assign diff      = (r_s1_cur > ram_rdata) ? (r_s1_cur - ram_rdata)
                                              : (ram_rdata - r_s1_cur);
    // First output row: the lower row times S, or the row itself when only
    // its own copies are emitted.
    assign row_m     = r_s1_row - RW'(r_s1_interp);
    assign base_full = BW'(row_m) * BW'(i_scale);

    always_comb begin
        o_job.lo        = ram_rdata;
        o_job.up        = r_s1_cur;
        o_job.row_base  = RWO'(base_full);
        o_job.col       = CWO'(r_s1_col);
        o_job.do_interp = r_s1_interp;
        o_job.do_last   = r_s1_last;
        o_job.is_edge   = i_edge_mode & (diff > i_threshold);
        o_job.is_zero   = (ram_rdata == '0) & (r_s1_cur == '0);
    end

endmodule

`default_nettype wire

>>> hdl/epvu_back.sv
`default_nettype none

module epvu_back #(
    parameter int MAX_SCALE = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [$clog2(MAX_SCALE+1)-1:0] i_scale,
    input  wire epvu_pkg::t_job                 i_job,
    input  wire logic                           i_job_empty,
    output logic                                o_job_pop,
    input  wire logic                           i_pop,
    output logic                                o_empty,
    output epvu_pkg::t_result                   o_result
);

    localparam int SW    = $clog2(MAX_SCALE + 1);
    localparam int KW    = $clog2(MAX_SCALE);
    localparam int DW    = epvu_pkg::SAMPLE_W;
    localparam int NW    = DW + SW;
    localparam int NUMW  = epvu_pkg::DIV_NUM_W;
    localparam int RCW   = epvu_pkg::RECIP_W;
    localparam int PRW   = NUMW + RCW;
    localparam int SH    = epvu_pkg::DIV_SHIFT;
    localparam int ROWW  = epvu_pkg::ROW_W;
    localparam int QD    = epvu_pkg::RES_QUEUE_DEPTH;
    localparam int CRW   = $clog2(QD + 1);

    // Phase sequencer.
    logic              r_busy;
    epvu_pkg::t_job    r_job;
    logic [KW-1:0]     r_k;
    logic              r_part;
    logic [ROWW-1:0]   r_orow;
    logic [CRW-1:0]    r_credit, n_credit;

    logic              issue, load, k_end, op_end, pop_ok;
    logic              op_bypass;
    logic [DW-1:0]     op_val;

    // Arithmetic pipeline.
    logic              r_p1_valid, r_p2_valid, r_p3_valid;
    epvu_pkg::t_result r_p1_res, r_p2_res, r_p3_res;
    logic              r_p1_bypass, r_p2_bypass, r_p3_bypass;
    logic [DW-1:0]     r_p1_lo, r_p1_up;
    logic [KW-1:0]     r_p1_k;
    logic [NW-1:0]     r_p2_num;
    logic [PRW-1:0]    r_p3_prod;
    logic [NW-1:0]     num;
    epvu_pkg::t_result res_data;

    assign pop_ok = i_pop & ~o_empty;
    // A phase issues only when a slot in the result queue is reserved for it.
    assign issue  = r_busy & (r_credit != '0);
    assign k_end  = (SW'(r_k) == (i_scale - SW'(1)));
    assign op_end = k_end & (r_part | ~r_job.do_last);
    assign load   = ~i_job_empty & (~r_busy | (issue & op_end));
    assign o_job_pop = load;

    always_comb begin
        op_bypass = 1'b1;
        op_val    = r_job.up;
        if (r_part) begin
            op_val = r_job.up;
        end else if (r_k == '0) begin
            op_val = r_job.lo;
        end else if (r_job.is_zero) begin
            op_val = '0;
        end else if (r_job.is_edge) begin
            op_val = ((SW + 1)'({r_k, 1'b0}) < (SW + 1)'(i_scale)) ? r_job.lo : r_job.up;
        end else begin
            op_bypass = 1'b0;
        end
    end

    assign n_credit = r_credit - CRW'(issue) + CRW'(pop_ok);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_credit   <= CRW'(QD);
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (issue && op_end) begin
                r_busy <= 1'b0;
            end
            r_credit   <= n_credit;
            r_p1_valid <= issue;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job  <= i_job;
            r_part <= ~i_job.do_interp;
            r_k    <= '0;
            r_orow <= i_job.row_base;
        end else if (issue) begin
            if (k_end) begin
                r_k    <= '0;
                r_part <= 1'b1;
            end else begin
                r_k <= r_k + KW'(1);
            end
            r_orow <= r_orow + ROWW'(1);
        end
    end

    assign num = NW'(r_p1_lo) * (NW'(i_scale) - NW'(r_p1_k)) + NW'(r_p1_up) * NW'(r_p1_k);

    always_ff @(posedge i_clk) begin
        r_p1_res.out_row <= r_orow;
        r_p1_res.out_col <= r_job.col;
        r_p1_res.value   <= op_val;
        r_p1_res.last    <= op_end;
        r_p1_bypass      <= op_bypass;
        r_p1_lo          <= r_job.lo;
        r_p1_up          <= r_job.up;
        r_p1_k           <= r_k;

        r_p2_res         <= r_p1_res;
        r_p2_bypass      <= r_p1_bypass;
        r_p2_num         <= num;

        r_p3_res         <= r_p2_res;
        r_p3_bypass      <= r_p2_bypass;
        r_p3_prod        <= PRW'(NUMW'(r_p2_num)) * PRW'(epvu_pkg::recip(5'(i_scale)));
    end

    always_comb begin
        res_data = r_p3_res;
        if (!r_p3_bypass) begin
            res_data.value = r_p3_prod[SH +: DW];
        end
    end

    epvu_queue #(
        .WIDTH ($bits(epvu_pkg::t_result)),
        .DEPTH (QD)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_p3_valid),
        .i_data  (res_data),
        .o_full  (),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty)
    );

endmodule

`default_nettype wire

>>> hdl/edge_preserving_vertical_upsampler_top.sv
// A sample accepted by the front passes its registered stage, the job queue, the back's
// sequencer and its p1, p2 and p3 registers on its way to the result queue. The back
// issues a result a cycle while it holds a job and one of its four result slots is free;
// a slot comes back only when a word is popped. Only samples after the first row or on the
// last row give words. Synchronous active-low reset empties both queues, clears the row and
// column counters and restores the configuration defaults; the line store is not cleared.
`default_nettype none

module edge_preserving_vertical_upsampler_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 128,
    parameter int MAX_SCALE  = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic [15:0] i_sample,
    output logic             o_full,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic [9:0]       o_out_row,
    output logic [10:0]      o_out_col,
    output logic [15:0]      o_value,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int SW = $clog2(MAX_SCALE + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [3:0]        r_scale;
    logic              r_edge_mode;
    logic [15:0]       r_threshold;
    logic [11:0]       r_width;
    logic [7:0]        r_height;

    logic [SW-1:0]     scale_eff;
    logic [WW-1:0]     width_eff;
    logic [HW-1:0]     height_eff;

    epvu_pkg::t_job    job_in, job_out;
    logic              jq_push, jq_full, jq_pop, jq_empty;
    epvu_pkg::t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= 4'd2;
            r_edge_mode <= 1'b1;
            r_threshold <= 16'd10;
            r_width     <= 12'd1024;
            r_height    <= 8'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                epvu_pkg::CFG_SCALE_FACTOR:   r_scale     <= i_cfg_data[3:0];
                epvu_pkg::CFG_EDGE_MODE:      r_edge_mode <= i_cfg_data[0];
                epvu_pkg::CFG_EDGE_THRESHOLD: r_threshold <= i_cfg_data;
                epvu_pkg::CFG_IMAGE_WIDTH:    r_width     <= i_cfg_data[11:0];
                epvu_pkg::CFG_IMAGE_HEIGHT:   r_height    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Zero acts as one, and values beyond the built size saturate.
    always_comb begin
        if (r_scale == '0) begin
            scale_eff = SW'(1);
        end else if (32'(r_scale) > MAX_SCALE) begin
            scale_eff = SW'(MAX_SCALE);
        end else begin
            scale_eff = SW'(r_scale);
        end
        if (r_width == '0) begin
            width_eff = WW'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(r_width);
        end
        if (r_height == '0) begin
            height_eff = HW'(1);
        end else if (32'(r_height) > MAX_HEIGHT) begin
            height_eff = HW'(MAX_HEIGHT);
        end else begin
            height_eff = HW'(r_height);
        end
    end

    epvu_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_SCALE  (MAX_SCALE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_sample    (i_sample),
        .o_full      (o_full),
        .i_scale     (scale_eff),
        .i_edge_mode (r_edge_mode),
        .i_threshold (r_threshold),
        .i_width     (width_eff),
        .i_height    (height_eff),
        .o_job       (job_in),
        .o_job_push  (jq_push),
        .i_job_full  (jq_full)
    );

    epvu_queue #(
        .WIDTH ($bits(epvu_pkg::t_job)),
        .DEPTH (epvu_pkg::JOB_QUEUE_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (jq_push),
        .i_data  (job_in),
        .o_full  (jq_full),
        .i_pop   (jq_pop),
        .o_data  (job_out),
        .o_empty (jq_empty)
    );

    epvu_back #(
        .MAX_SCALE (MAX_SCALE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scale     (scale_eff),
        .i_job       (job_out),
        .i_job_empty (jq_empty),
        .o_job_pop   (jq_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_result    (result)
    );

    assign o_out_row = result.out_row;
    assign o_out_col = result.out_col;
    assign o_value   = result.value;
    assign o_last    = result.last;

    a_job_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        jq_push |-> !jq_full)
        else $error("job pushed into a full queue");

    a_job_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        jq_pop |-> !jq_empty)
        else $error("job popped from an empty queue");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !jq_push))
        else $error("results or jobs present right after reset");

endmodule

`default_nettype wire
